[hw/rtl/tdrc_pkg.sv]
`timescale 1ns / 1ps

package tdrc_pkg;

   // Action codes of an input transaction (code 3 carries no meaning)
   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_PACKET = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // Kind of packet to send
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RRQ  = 2'd1;
   localparam logic [1:0] KIND_ACK  = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   // Protocol opcodes and error codes
   localparam logic [15:0] OP_DATA         = 16'd3;
   localparam logic [15:0] OP_ERROR        = 16'd5;
   localparam logic [15:0] ERR_ILLEGAL_OP  = 16'd4;
   localparam logic [15:0] ERR_UNKNOWN_TID = 16'd5;

   // Register indexes
   localparam logic [1:0] REG_SERVER_ADDRESS = 2'd0;
   localparam logic [1:0] REG_WELL_KNOWN     = 2'd1;
   localparam logic [1:0] REG_TIMEOUT        = 2'd2;
   localparam logic [1:0] REG_FLASH_BASE     = 2'd3;

   // Register reset values
   localparam logic [31:0] SERVER_ADDRESS_RESET = 32'hC0A8_0102;
   localparam logic [15:0] WELL_KNOWN_RESET     = 16'd69;
   localparam logic [19:0] TIMEOUT_RESET        = 20'(3 * 100000);
   localparam logic [31:0] FLASH_BASE_RESET     = 32'd0;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RUN  = 2'd1,
      PH_DONE = 2'd2,
      PH_FAIL = 2'd3
   } phase_type;

   // Packet class decided by the front end
   typedef enum logic [1:0] {
      CLS_RUNT    = 2'd0,
      CLS_DATA    = 2'd1,
      CLS_ERROR   = 2'd2,
      CLS_ILLEGAL = 2'd3
   } class_type;

   // Classified transaction passed from front to back
   typedef struct packed {
      logic [1:0]  action;
      logic        addr_ok;
      class_type   cls;
      logic [15:0] port;
      logic [15:0] block;
      logic        write_ok;
      logic        short_block;
      logic [9:0]  length;
   } cmd_type;

   // Settings used by the back end
   typedef struct packed {
      logic [15:0] well_known_port;
      logic [19:0] timeout_ticks;
      logic [31:0] flash_base_address;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic [1:0]  send_kind;
      logic [15:0] send_value;
      logic [15:0] send_port;
      logic        write_enable;
      logic [31:0] write_address;
      logic [9:0]  write_length;
      logic [1:0]  transfer_status;
   } rsp_type;

endpackage

[hw/rtl/tdrc_front.sv]
`timescale 1ns / 1ps

module tdrc_front
   import tdrc_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  action,
   input  logic [31:0] source_address,
   input  logic [15:0] source_port,
   input  logic [10:0] packet_length,
   input  logic [15:0] packet_opcode,
   input  logic [15:0] packet_block,
   input  logic [31:0] server_address,
   output logic        cmd_valid,
   input  logic        cmd_pop,
   output cmd_type     cmd
);

   localparam logic [10:0] MaxBytes = 11'(MAX_DATA_BYTES);

   cmd_type     q_ff [2];
   cmd_type     cmd_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic [10:0] payload;
   logic        is_runt;

   // Classify the incoming transaction
   always_comb begin
      payload = packet_length - 11'd4;
      is_runt = (packet_length < 11'd2) ||
                ((packet_opcode == OP_DATA) && (packet_length < 11'd4));
      cmd_in.action  = action;
      cmd_in.addr_ok = (source_address == server_address);
      if (is_runt) begin
         cmd_in.cls = CLS_RUNT;
      end else if (packet_opcode == OP_DATA) begin
         cmd_in.cls = CLS_DATA;
      end else if (packet_opcode == OP_ERROR) begin
         cmd_in.cls = CLS_ERROR;
      end else begin
         cmd_in.cls = CLS_ILLEGAL;
      end
      cmd_in.port        = source_port;
      cmd_in.block       = packet_block;
      cmd_in.write_ok    = (payload != 11'd0) && (payload <= MaxBytes);
      cmd_in.short_block = (payload < MaxBytes);
      cmd_in.length      = payload[9:0];
   end

   // Two-entry queue toward the back end
   assign full      = (count_ff == 2'd2);
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + {1'b0, accept} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

[hw/rtl/tdrc_back.sv]
`timescale 1ns / 1ps

module tdrc_back
   import tdrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   input  cfg_type cfg,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   phase_type   phase_ff, phase_in;
   logic [15:0] remote_port_ff, remote_port_in;
   logic        latched_ff, latched_in;
   logic [15:0] last_block_ff, last_block_in;
   logic [31:0] next_address_ff, next_address_in;
   logic [19:0] idle_ticks_ff, idle_ticks_in;

   rsp_type     q_ff [2];
   rsp_type     res_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        exec;
   logic        accept_out;
   logic        port_diff;
   logic [15:0] eff_port;
   logic [16:0] block_limit;

   // Execute one transaction whenever the result queue has room
   assign exec       = cmd_valid && (count_ff != 2'd2);
   assign cmd_pop    = exec;
   assign accept_out = rsp_pop && !rsp_empty;

   // Next state and result of the transfer
   always_comb begin
      phase_in        = phase_ff;
      remote_port_in  = remote_port_ff;
      latched_in      = latched_ff;
      last_block_in   = last_block_ff;
      next_address_in = next_address_ff;
      idle_ticks_in   = idle_ticks_ff;
      res_in          = '0;
      port_diff       = (cmd.port != remote_port_ff);
      eff_port        = port_diff ? cmd.port : remote_port_ff;
      block_limit     = {1'b0, last_block_ff} + 17'd1;

      if (exec) begin
         unique case (cmd.action)
            ACT_START: begin
               remote_port_in   = cfg.well_known_port;
               latched_in       = 1'b0;
               last_block_in    = 16'd0;
               next_address_in  = cfg.flash_base_address;
               idle_ticks_in    = 20'd0;
               phase_in         = PH_RUN;
               res_in.send_kind = KIND_RRQ;
               res_in.send_port = cfg.well_known_port;
            end
            ACT_TICK: begin
               if (phase_ff == PH_RUN) begin
                  if (idle_ticks_ff >= cfg.timeout_ticks) begin
                     phase_in = PH_FAIL;
                  end else begin
                     idle_ticks_in = idle_ticks_ff + 20'd1;
                  end
               end
            end
            ACT_PACKET: begin
               if (phase_ff == PH_RUN) begin
                  idle_ticks_in = 20'd0;
                  if (cmd.addr_ok) begin
                     if (port_diff && latched_ff) begin
                        // Foreign transfer port: reject and drop
                        res_in.send_kind  = KIND_ERR;
                        res_in.send_value = ERR_UNKNOWN_TID;
                        res_in.send_port  = remote_port_ff;
                     end else begin
                        if (port_diff) begin
                           remote_port_in = cmd.port;
                           latched_in     = 1'b1;
                        end
                        unique case (cmd.cls)
                           CLS_RUNT: begin
                              phase_in = PH_FAIL;
                           end
                           CLS_DATA: begin
                              if ((cmd.block == 16'd0) ||
                                  ({1'b0, cmd.block} > block_limit)) begin
                                 phase_in = PH_FAIL;
                              end else begin
                                 res_in.send_kind  = KIND_ACK;
                                 res_in.send_value = cmd.block;
                                 res_in.send_port  = eff_port;
                                 if (cmd.block > last_block_ff) begin
                                    last_block_in = cmd.block;
                                    if (cmd.write_ok) begin
                                       res_in.write_enable  = 1'b1;
                                       res_in.write_address = next_address_ff;
                                       res_in.write_length  = cmd.length;
                                       next_address_in = next_address_ff +
                                                         {22'd0, cmd.length};
                                    end
                                    if (cmd.short_block) begin
                                       phase_in = PH_DONE;
                                    end
                                 end
                              end
                           end
                           CLS_ERROR: begin
                              phase_in = PH_FAIL;
                           end
                           CLS_ILLEGAL: begin
                              res_in.send_kind  = KIND_ERR;
                              res_in.send_value = ERR_ILLEGAL_OP;
                              res_in.send_port  = eff_port;
                           end
                           default: begin
                              phase_in = phase_ff;
                           end
                        endcase
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      res_in.transfer_status = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         remote_port_ff  <= WELL_KNOWN_RESET;
         latched_ff      <= 1'b0;
         last_block_ff   <= 16'd0;
         next_address_ff <= FLASH_BASE_RESET;
         idle_ticks_ff   <= 20'd0;
      end else begin
         phase_ff        <= phase_in;
         remote_port_ff  <= remote_port_in;
         latched_ff      <= latched_in;
         last_block_ff   <= last_block_in;
         next_address_ff <= next_address_in;
         idle_ticks_ff   <= idle_ticks_in;
      end
   end

   // Two-entry result queue
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ exec;
      rd_ptr_in = rd_ptr_ff ^ accept_out;
      count_in  = count_ff + {1'b0, exec} - {1'b0, accept_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         q_ff[wr_ptr_ff] <= res_in;
      end
   end

endmodule

[hw/rtl/tftp_download_receive_control.sv]
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// req       req_push / req_full  action, source address/port, length, opcode, block
// rsp       rsp_pop / rsp_empty  send kind/value/port, flash write, transfer status
// csr       APB write/read       server address, well-known port, timeout, flash base
//
// One transaction per cycle sustained while neither queue is full; each request yields exactly one result.
// A request is held in the front queue, then executed by the back end into the result queue.
// Two-entry queues on each side let input and output stall independently.
// Reset is synchronous; the transfer returns to idle and registers take defaults.

module tftp_download_receive_control
   import tdrc_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_source_address,
   input  logic [15:0] req_source_port,
   input  logic [10:0] req_packet_length,
   input  logic [15:0] req_packet_opcode,
   input  logic [15:0] req_packet_block,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_send_kind,
   output logic [15:0] rsp_send_value,
   output logic [15:0] rsp_send_port,
   output logic        rsp_write_enable,
   output logic [31:0] rsp_write_address,
   output logic [9:0]  rsp_write_length,
   output logic [1:0]  rsp_transfer_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] server_address_ff;
   logic [15:0] well_known_ff;
   logic [19:0] timeout_ff;
   logic [31:0] flash_base_ff;
   logic        csr_write;
   cfg_type     cfg;
   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_pop;
   rsp_type     rsp;

   // Register write and readback
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_address_ff <= SERVER_ADDRESS_RESET;
         well_known_ff     <= WELL_KNOWN_RESET;
         timeout_ff        <= TIMEOUT_RESET;
         flash_base_ff     <= FLASH_BASE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_SERVER_ADDRESS: server_address_ff <= csr_pwdata;
            REG_WELL_KNOWN:     well_known_ff     <= csr_pwdata[15:0];
            REG_TIMEOUT:        timeout_ff        <= csr_pwdata[19:0];
            REG_FLASH_BASE:     flash_base_ff     <= csr_pwdata;
            default:            flash_base_ff     <= flash_base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SERVER_ADDRESS: csr_prdata = server_address_ff;
         REG_WELL_KNOWN:     csr_prdata = {16'd0, well_known_ff};
         REG_TIMEOUT:        csr_prdata = {12'd0, timeout_ff};
         REG_FLASH_BASE:     csr_prdata = flash_base_ff;
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg.well_known_port    = well_known_ff;
   assign cfg.timeout_ticks      = timeout_ff;
   assign cfg.flash_base_address = flash_base_ff;

   // Accept and classify
   tdrc_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .full           (req_full),
      .action         (req_action),
      .source_address (req_source_address),
      .source_port    (req_source_port),
      .packet_length  (req_packet_length),
      .packet_opcode  (req_packet_opcode),
      .packet_block   (req_packet_block),
      .server_address (server_address_ff),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd)
   );

   // Run the transfer state and queue results
   tdrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .cfg       (cfg),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_send_kind       = rsp.send_kind;
   assign rsp_send_value      = rsp.send_value;
   assign rsp_send_port       = rsp.send_port;
   assign rsp_write_enable    = rsp.write_enable;
   assign rsp_write_address   = rsp.write_address;
   assign rsp_write_length    = rsp.write_length;
   assign rsp_transfer_status = rsp.transfer_status;

`ifndef ASSERT_OFF
   // Back end pops only a waiting transaction
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("back end popped an empty command queue");

   // A flash write always comes with an ack and a nonzero length
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_write_enable) |->
         (rsp_send_kind == KIND_ACK) && (rsp_write_length != 10'd0))
      else $error("flash write without ack");

   // Nothing is sent while no transfer has started
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_transfer_status == PH_IDLE)) |-> (rsp_send_kind == KIND_NONE))
      else $error("packet sent while idle");

   // A read request always starts a running transfer
   a_rrq_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_send_kind == KIND_RRQ)) |-> (rsp_transfer_status == PH_RUN))
      else $error("read request without running transfer");
`endif

endmodule

[dv/tftp_download_receive_control_tb.sv]
`timescale 1ns / 1ps

module tftp_download_receive_control_tb;
   import tdrc_pkg::*;

   localparam int          PAYLOAD_MAX = 512;
   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;
   localparam logic [10:0] FULL_BLOCK  = 11'(PAYLOAD_MAX + 4);

   typedef struct {
      logic [1:0]  action;
      logic [31:0] addr;
      logic [15:0] sport;
      logic [10:0] len;
      logic [15:0] opcode;
      logic [15:0] blk;
   } packet_item;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_action = ACT_TICK;
   logic [31:0] req_source_address = '0;
   logic [15:0] req_source_port = '0;
   logic [10:0] req_packet_length = '0;
   logic [15:0] req_packet_opcode = '0;
   logic [15:0] req_packet_block = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_send_kind;
   logic [15:0] rsp_send_value;
   logic [15:0] rsp_send_port;
   logic        rsp_write_enable;
   logic [31:0] rsp_write_address;
   logic [9:0]  rsp_write_length;
   logic [1:0]  rsp_transfer_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tftp_download_receive_control #(
      .MAX_DATA_BYTES(PAYLOAD_MAX)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_action         (req_action),
      .req_source_address (req_source_address),
      .req_source_port    (req_source_port),
      .req_packet_length  (req_packet_length),
      .req_packet_opcode  (req_packet_opcode),
      .req_packet_block   (req_packet_block),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_send_kind      (rsp_send_kind),
      .rsp_send_value     (rsp_send_value),
      .rsp_send_port      (rsp_send_port),
      .rsp_write_enable   (rsp_write_enable),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_length   (rsp_write_length),
      .rsp_transfer_status(rsp_transfer_status),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Settings as last written
   logic [31:0] cfg_server   = SERVER_ADDRESS_RESET;
   logic [15:0] cfg_wk_port  = WELL_KNOWN_RESET;
   logic [19:0] cfg_timeout  = TIMEOUT_RESET;
   logic [31:0] cfg_flash    = FLASH_BASE_RESET;

   // Transfer state tracked alongside the block
   phase_type   tr_phase     = PH_IDLE;
   logic [15:0] tr_port      = WELL_KNOWN_RESET;
   logic        tr_latched   = 1'b0;
   logic [15:0] tr_last_blk  = '0;
   logic [31:0] tr_next_addr = FLASH_BASE_RESET;
   logic [19:0] tr_idle      = '0;

   packet_item  rx_item_q[$];
   rsp_type     predicted_reply_q[$];
   packet_item  drv_item;
   rsp_type     want_reply;
   int          queued_total = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          gap_odds = 8;

   // Compute the reply of one transaction and advance the transfer state
   function automatic rsp_type predict_transfer(packet_item it);
      rsp_type     r;
      logic [10:0] payload;
      logic        go;
      r = '0;
      case (it.action)
         ACT_START: begin
            tr_port      = cfg_wk_port;
            tr_latched   = 1'b0;
            tr_last_blk  = '0;
            tr_next_addr = cfg_flash;
            tr_idle      = '0;
            tr_phase     = PH_RUN;
            r.send_kind  = KIND_RRQ;
            r.send_port  = cfg_wk_port;
         end
         ACT_TICK: begin
            if (tr_phase == PH_RUN) begin
               if (tr_idle >= cfg_timeout) tr_phase = PH_FAIL;
               else tr_idle = tr_idle + 20'd1;
            end
         end
         ACT_PACKET: begin
            if (tr_phase == PH_RUN) begin
               tr_idle = '0;
               if (it.addr == cfg_server) begin
                  go = 1'b1;
                  // Latch the first new port, refuse any later change
                  if (it.sport != tr_port) begin
                     if (!tr_latched) begin
                        tr_port    = it.sport;
                        tr_latched = 1'b1;
                     end else begin
                        r.send_kind  = KIND_ERR;
                        r.send_value = ERR_UNKNOWN_TID;
                        r.send_port  = tr_port;
                        go = 1'b0;
                     end
                  end
                  if (go) begin
                     if (it.len < 11'd2) begin
                        tr_phase = PH_FAIL;
                     end else if (it.opcode == OP_DATA) begin
                        payload = it.len - 11'd4;
                        if (it.len < 11'd4) begin
                           tr_phase = PH_FAIL;
                        end else if (it.blk == '0 ||
                                     {1'b0, it.blk} > {1'b0, tr_last_blk} + 17'd1) begin
                           tr_phase = PH_FAIL;
                        end else begin
                           r.send_kind  = KIND_ACK;
                           r.send_value = it.blk;
                           r.send_port  = tr_port;
                           // Write only new blocks; duplicates are acked again
                           if (it.blk > tr_last_blk) begin
                              tr_last_blk = it.blk;
                              if (payload != '0 && payload <= 11'(PAYLOAD_MAX)) begin
                                 r.write_enable  = 1'b1;
                                 r.write_address = tr_next_addr;
                                 r.write_length  = payload[9:0];
                                 tr_next_addr    = tr_next_addr + 32'(payload);
                              end
                              if (payload < 11'(PAYLOAD_MAX)) tr_phase = PH_DONE;
                           end
                        end
                     end else if (it.opcode == OP_ERROR) begin
                        tr_phase = PH_FAIL;
                     end else begin
                        r.send_kind  = KIND_ERR;
                        r.send_value = ERR_ILLEGAL_OP;
                        r.send_port  = tr_port;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.transfer_status = tr_phase;
      return r;
   endfunction

   function automatic void add_item(logic [1:0] action, logic [31:0] addr, logic [15:0] sport,
                                    logic [10:0] len, logic [15:0] opcode, logic [15:0] blk);
      packet_item it;
      it.action = action;
      it.addr   = addr;
      it.sport  = sport;
      it.len    = len;
      it.opcode = opcode;
      it.blk    = blk;
      rx_item_q.push_back(it);
      queued_total++;
   endfunction

   // Queue one unrelated transaction with random content
   function automatic void add_noise();
      logic [1:0]  action;
      logic [15:0] opcode;
      action = ACT_PACKET;
      if ($urandom_range(0, 9) == 0) action = ACT_TICK;
      else if ($urandom_range(0, 39) == 0) action = ACT_UNUSED;
      case ($urandom_range(0, 3))
         0, 1:    opcode = OP_DATA;
         2:       opcode = OP_ERROR;
         default: opcode = 16'($urandom);
      endcase
      add_item(action, $urandom_range(0, 1) ? cfg_server : $urandom, 16'($urandom),
               11'($urandom_range(0, 1024)), opcode, 16'($urandom));
   endfunction

   // Queue a read transfer of a few blocks, with occasional strays and faults
   function automatic void queue_transfer(int unsigned blocks);
      logic [15:0] sport;
      logic [10:0] len;
      sport = ($urandom_range(0, 7) == 0) ? cfg_wk_port : 16'($urandom);
      add_item(ACT_START, $urandom, 16'($urandom), 11'($urandom_range(0, 1024)),
               16'($urandom), 16'($urandom));
      for (int unsigned b = 1; b <= blocks; b++) begin
         case ($urandom_range(0, 23))
            0: repeat ($urandom_range(1, 4)) add_item(ACT_TICK, $urandom, 16'($urandom),
                                                      11'($urandom_range(0, 1024)),
                                                      16'($urandom), 16'($urandom));
            1: add_item(ACT_PACKET, cfg_server ^ 32'($urandom_range(1, 32'hFFFF_FFFF)),
                        sport, FULL_BLOCK, OP_DATA, 16'(b));
            2: add_item(ACT_PACKET, cfg_server, sport ^ 16'($urandom_range(1, 65535)),
                        FULL_BLOCK, OP_DATA, 16'(b));
            3: add_item(ACT_PACKET, cfg_server, sport, 11'($urandom_range(2, 1024)),
                        16'($urandom_range(6, 65535)), 16'($urandom));
            4: if (b > 1) add_item(ACT_PACKET, cfg_server, sport, FULL_BLOCK, OP_DATA,
                                   16'($urandom_range(1, b - 1)));
            5: begin
               add_item(ACT_PACKET, cfg_server, sport, 11'($urandom_range(2, 1024)),
                        OP_ERROR, 16'($urandom));
               return;
            end
            6: begin
               if ($urandom_range(0, 1) == 0)
                  add_item(ACT_PACKET, cfg_server, sport, 11'($urandom_range(0, 1)),
                           16'($urandom), 16'(b));
               else
                  add_item(ACT_PACKET, cfg_server, sport, 11'($urandom_range(2, 3)),
                           OP_DATA, 16'(b));
               return;
            end
            7: begin
               add_item(ACT_PACKET, cfg_server, sport, FULL_BLOCK, OP_DATA,
                        $urandom_range(0, 1) ? 16'd0 : 16'(b + $urandom_range(1, 60000)));
               return;
            end
            default: ;
         endcase
         if (b == blocks)
            len = ($urandom_range(0, 5) == 0) ? 11'd4 : 11'($urandom_range(5, PAYLOAD_MAX + 3));
         else if ($urandom_range(0, 9) == 0)
            len = 11'($urandom_range(PAYLOAD_MAX + 5, 1024));
         else
            len = FULL_BLOCK;
         add_item(ACT_PACKET, cfg_server, sport, len, OP_DATA, 16'(b));
      end
   endfunction

   // Fill the pending queue with mostly well-formed transfers
   function automatic void queue_random_traffic(int target);
      int first;
      first = queued_total;
      while (queued_total - first < target) begin
         if ($urandom_range(0, 4) != 0) queue_transfer($urandom_range(1, 6));
         else repeat ($urandom_range(1, 4)) add_noise();
      end
   endfunction

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Hold off until every queued transaction is sent and answered
   task automatic wait_drained();
      while (rx_item_q.size() != 0 || req_push || predicted_reply_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      logic [31:0] mask;
      case (idx)
         REG_WELL_KNOWN: mask = 32'h0000_FFFF;
         REG_TIMEOUT:    mask = 32'h000F_FFFF;
         default:        mask = 32'hFFFF_FFFF;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SERVER_ADDRESS: cfg_server  = value;
         REG_WELL_KNOWN:     cfg_wk_port = value[15:0];
         REG_TIMEOUT:        cfg_timeout = value[19:0];
         default:            cfg_flash   = value;
      endcase
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("register readback", value & mask, csr_prdata & mask);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // Driver: advance through the pending queue with random send gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full)
            predicted_reply_q.push_back(predict_transfer(drv_item));
         if (!req_push || !req_full) begin
            if (send_gap != 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (rx_item_q.size() != 0 && gap_odds != 0 &&
                         $urandom_range(1, gap_odds) == 1) begin
               send_gap = $urandom_range(0, 11);
               req_push <= 1'b0;
            end else if (rx_item_q.size() != 0) begin
               drv_item = rx_item_q.pop_front();
               req_action         <= drv_item.action;
               req_source_address <= drv_item.addr;
               req_source_port    <= drv_item.sport;
               req_packet_length  <= drv_item.len;
               req_packet_opcode  <= drv_item.opcode;
               req_packet_block   <= drv_item.blk;
               req_push           <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall the result side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_gap = 0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_pop <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         recv_gap = $urandom_range(0, 11);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (predicted_reply_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d status %0d",
                     $time, rsp_send_kind, rsp_transfer_status);
            error_count++;
         end else begin
            want_reply = predicted_reply_q.pop_front();
            check_field("send_kind", want_reply.send_kind, rsp_send_kind);
            check_field("send_value", want_reply.send_value, rsp_send_value);
            check_field("send_port", want_reply.send_port, rsp_send_port);
            check_field("write_enable", want_reply.write_enable, rsp_write_enable);
            check_field("write_address", want_reply.write_address, rsp_write_address);
            check_field("write_length", want_reply.write_length, rsp_write_length);
            check_field("transfer_status", want_reply.transfer_status, rsp_transfer_status);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed cases under reset settings
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, WELL_KNOWN_RESET, FULL_BLOCK, OP_DATA, 16'd1);
      add_item(ACT_TICK, '0, '0, '0, '0, '0);
      add_item(ACT_UNUSED, '1, '1, 11'd1024, '1, '1);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, ~SERVER_ADDRESS_RESET, 16'd1234, FULL_BLOCK, OP_DATA, 16'd1);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, WELL_KNOWN_RESET, FULL_BLOCK, OP_DATA, 16'd1);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, FULL_BLOCK, OP_DATA, 16'd2);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1235, FULL_BLOCK, OP_DATA, 16'd3);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, FULL_BLOCK, OP_DATA, 16'd1);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, 11'd4, 16'hFFFF, 16'hFFFF);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, 11'd1024, OP_DATA, 16'd3);
      add_item(ACT_TICK, '1, '1, '1, '1, '1);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, 11'd4, OP_DATA, 16'd4);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd1234, FULL_BLOCK, OP_DATA, 16'd5);
      add_item(ACT_START, '1, '1, 11'd1024, '1, '1);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'hFFFF, 11'd1, OP_DATA, 16'd1);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd0, 11'd3, OP_DATA, 16'd1);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd7, FULL_BLOCK, OP_DATA, 16'd0);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd7, FULL_BLOCK, OP_DATA, 16'd2);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd7, 11'd20, OP_ERROR, 16'd1);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, SERVER_ADDRESS_RESET, 16'd7, 11'd0, '0, '0);
      wait_drained();

      // Random settings, heavy idling on both sides
      gap_odds = 4;
      write_register(REG_SERVER_ADDRESS, $urandom);
      write_register(REG_WELL_KNOWN, 32'($urandom_range(0, 65535)));
      write_register(REG_TIMEOUT, 32'd3);
      write_register(REG_FLASH_BASE, $urandom);
      queue_random_traffic(430);
      wait_drained();

      // Low extremes; flash address wraps from the top
      gap_odds = 16;
      write_register(REG_SERVER_ADDRESS, 32'h0000_0000);
      write_register(REG_WELL_KNOWN, 32'h0000_0000);
      write_register(REG_TIMEOUT, 32'd1);
      write_register(REG_FLASH_BASE, 32'hFFFF_FFFF);
      add_item(ACT_START, '0, '0, '0, '0, '0);
      add_item(ACT_TICK, '0, '0, '0, '0, '0);
      add_item(ACT_PACKET, 32'h0000_0000, 16'd9, FULL_BLOCK, OP_DATA, 16'd1);
      add_item(ACT_TICK, '0, '0, '0, '0, '0);
      add_item(ACT_TICK, '0, '0, '0, '0, '0);
      add_item(ACT_TICK, '0, '0, '0, '0, '0);
      queue_random_traffic(430);
      wait_drained();

      // High extremes, no idling to the end
      gap_odds = 0;
      write_register(REG_SERVER_ADDRESS, 32'hFFFF_FFFF);
      write_register(REG_WELL_KNOWN, 32'h0000_FFFF);
      write_register(REG_TIMEOUT, 32'h000F_FFFF);
      write_register(REG_FLASH_BASE, $urandom);
      queue_random_traffic(430);
      wait_drained();

      repeat (20) @(posedge clock);
      if (predicted_reply_q.size() != 0) begin
         $display("%0t: results missing: expected %0d more, actual 0",
                  $time, predicted_reply_q.size());
         error_count++;
      end
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
